>>> sv/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
// Used by the controller, the datapath and the top level.
package sha_pkg;

    localparam int WordW  = 32;
    localparam int CountW = 61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } sha_state_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic       absorb;       // write request byte into block
        logic       pad;          // write 0x80 marker at current offset
        logic       put_len;      // write length into words 14 and 15
        logic       load_work;    // copy chaining value to working vars, clear round
        logic       round;        // run one round
        logic       add_cv;       // fold working vars into chaining value, clear block
        logic       rehash;       // load digest as new message of 32 bytes
        logic       init;         // restart message
    } sha_cmd_t;

    // Datapath status to controller
    typedef struct packed {
        logic [5:0] offset;       // byte offset within block
        logic       last_round;
    } sha_stat_t;

    localparam logic [WordW-1:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WordW-1:0] RoundK [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [7:0] PadByte   = 8'h80;
    localparam logic [5:0] LenOffset = 6'd56;

    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage

>>> sv/sha_ctrl.sv
// Sequencing controller of the SHA-256 stream hasher.
// Depends on sha_pkg; drives sha_dp through command and status structs.
module sha_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    input  logic               req_byte,
    input  logic               req_end,
    input  logic               double_hash,
    input  sha_pkg::sha_stat_t stat,
    input  logic               out_taken,
    output logic               req_ready,
    output logic               out_valid,
    output logic [2:0]         out_index,
    output sha_pkg::sha_cmd_t  cmd
);
    import sha_pkg::*;

    sha_state_t state_reg, state_next;
    logic       final_reg, final_next;     // block being run carries the length
    logic       second_reg, second_next;   // end of message pending after a full data block
    logic       dbl_reg, dbl_next;
    logic [2:0] idx_reg, idx_next;
    logic       accept;
    logic [5:0] off_after;

    assign accept    = req_valid && req_ready;
    // offset once this request's byte is in
    assign off_after = stat.offset + {5'd0, req_byte};

    // Next state
    always_comb begin
        state_next  = state_reg;
        final_next  = final_reg;
        second_next = second_reg;
        dbl_next    = dbl_reg;
        idx_next    = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req_byte && stat.offset == 6'd63) begin
                        // full block: compress, finish afterward if end
                        state_next = ST_ROUND;
                        final_next = 1'b0;
                        second_next = req_end;
                        dbl_next   = double_hash;
                    end else if (req_end) begin
                        state_next = ST_ROUND;
                        final_next = (off_after < LenOffset);
                        dbl_next   = double_hash;
                        second_next = 1'b0;
                    end
                end
            end
            ST_ROUND: begin
                if (stat.last_round) state_next = ST_ADD;
            end
            ST_ADD: begin
                // second_reg here flags "end pending after a full data block"
                if (second_reg && !final_reg) begin
                    state_next  = ST_ROUND;
                    final_next  = 1'b1;
                    second_next = 1'b0;
                end else if (!final_reg) begin
                    if (idx_reg == 3'd1) begin
                        // marker placed earlier; now the length block
                        state_next = ST_ROUND;
                        final_next = 1'b1;
                        idx_next   = 3'd0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (dbl_reg) begin
                    state_next = ST_ROUND;
                    dbl_next   = 1'b0;
                    final_next = 1'b1;
                end else begin
                    state_next = ST_OUT;
                    idx_next   = 3'd0;
                end
            end
            ST_OUT: begin
                if (out_taken) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // end arriving with overflow into an extra block
        if (state_reg == ST_IDLE && accept && req_end
            && !(req_byte && stat.offset == 6'd63) && off_after >= LenOffset)
            idx_next = 3'd1;
    end

    // Outputs
    always_comb begin
        cmd       = '0;
        req_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        out_index = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.absorb = accept && req_byte;
                if (accept && req_end && !(req_byte && stat.offset == 6'd63)) begin
                    cmd.pad       = 1'b1;
                    cmd.put_len   = (off_after < LenOffset);
                end
                cmd.load_work = accept && (req_end || (req_byte && stat.offset == 6'd63));
            end
            ST_ROUND: cmd.round = 1'b1;
            ST_ADD: begin
                cmd.add_cv = 1'b1;
                if (second_reg && !final_reg) begin
                    // pad at offset 0 with length
                    cmd.pad = 1'b1; cmd.put_len = 1'b1; cmd.load_work = 1'b1;
                end else if (!final_reg && idx_reg == 3'd1) begin
                    cmd.put_len = 1'b1; cmd.load_work = 1'b1;
                end else if (final_reg && dbl_reg) begin
                    cmd.rehash = 1'b1; cmd.load_work = 1'b1;
                end
            end
            ST_OUT: cmd.init = out_taken && idx_reg == 3'd7;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            dbl_reg    <= 1'b0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            final_reg  <= final_next;
            second_reg <= second_next;
            dbl_reg    <= dbl_next;
            idx_reg    <= idx_next;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req_ready |-> !out_valid) else $error("ready while outputting");
    a_out_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_taken && out_index != 3'd7) |=> out_valid)
        else $error("digest burst broken");
    a_round_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && stat.last_round) |=> state_reg == ST_ADD)
        else $error("round count lost");
endmodule

>>> sv/sha_dp.sv
// Datapath of the SHA-256 stream hasher: block buffer, schedule window,
// round unit, chaining value and byte counter. Depends on sha_pkg.
module sha_dp (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sha_pkg::sha_cmd_t        cmd,
    input  logic [7:0]               data_byte,
    input  logic [2:0]               out_index,
    output sha_pkg::sha_stat_t       stat,
    output logic [sha_pkg::WordW-1:0] digest
);
    import sha_pkg::*;

    logic [WordW-1:0]  blk_reg [16];   // block words, then schedule window
    logic [WordW-1:0]  cv_reg  [8];
    logic [WordW-1:0]  wv_reg  [8];
    logic [CountW-1:0] cnt_reg;
    logic [5:0]        rnd_reg;
    logic              run_reg;         // registered copy of the round command

    logic [5:0]        off;
    logic [5:0]        pad_off;
    logic [WordW-1:0]  w_new, t1, t2, s0, s1;
    logic [CountW+2:0] bits;

    assign off     = cnt_reg[5:0];
    // marker goes after the byte written in the same cycle
    assign pad_off = off + {5'd0, cmd.absorb};
    assign bits    = {cnt_reg, 3'b000};
    assign stat.offset     = off;
    assign stat.last_round = (rnd_reg == 6'd63);
    assign digest  = cv_reg[out_index];

    // Message schedule and one round
    always_comb begin
        s0 = rotr(blk_reg[1], 7) ^ rotr(blk_reg[1], 18) ^ (blk_reg[1] >> 3);
        s1 = rotr(blk_reg[14], 17) ^ rotr(blk_reg[14], 19) ^ (blk_reg[14] >> 10);
        w_new = blk_reg[0] + s0 + blk_reg[9] + s1;
        t1 = wv_reg[7] + (rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25))
           + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6])) + RoundK[rnd_reg] + blk_reg[0];
        t2 = (rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22))
           + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    // Control-state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rnd_reg <= '0;
            run_reg <= 1'b0;
        end else begin
            if (cmd.absorb) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.rehash) cnt_reg <= CountW'(32);
            if (cmd.init)   cnt_reg <= '0;
            if (cmd.load_work) rnd_reg <= '0;
            else if (cmd.round) rnd_reg <= rnd_reg + 6'd1;
            run_reg <= cmd.round;
        end
    end

    // Chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.init || (cmd.rehash && 1'b0)) begin
            for (int i = 0; i < 8; i++) cv_reg[i] <= InitH[i];
        end else if (cmd.rehash) begin
            for (int i = 0; i < 8; i++) cv_reg[i] <= InitH[i];
        end else if (cmd.add_cv) begin
            for (int i = 0; i < 8; i++) cv_reg[i] <= cv_reg[i] + wv_reg[i];
        end
    end

    // Working variables
    always_ff @(posedge aclk) begin
        if (cmd.load_work) begin
            for (int i = 0; i < 8; i++)
                wv_reg[i] <= cmd.rehash ? InitH[i] :
                             (cmd.add_cv ? cv_reg[i] + wv_reg[i] : cv_reg[i]);
        end else if (cmd.round) begin
            wv_reg[0] <= t1 + t2;
            wv_reg[1] <= wv_reg[0];
            wv_reg[2] <= wv_reg[1];
            wv_reg[3] <= wv_reg[2];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[5] <= wv_reg[4];
            wv_reg[6] <= wv_reg[5];
            wv_reg[7] <= wv_reg[6];
        end
    end

    // Block buffer: clear at reset and on fold, load bytes or rehash digest, pad, length, shift as schedule window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) blk_reg[i] <= '0;
        end else if (cmd.round) begin
            for (int i = 0; i < 15; i++) blk_reg[i] <= blk_reg[i+1];
            blk_reg[15] <= w_new;
        end else begin
            if (cmd.add_cv) begin
                for (int i = 0; i < 16; i++) blk_reg[i] <= '0;
            end
            if (cmd.rehash) begin
                for (int i = 0; i < 8; i++) blk_reg[i] <= cv_reg[i] + wv_reg[i];
                blk_reg[8]  <= {PadByte, 24'd0};
                blk_reg[15] <= 32'd256;
            end
            if (cmd.absorb)
                blk_reg[off[5:2]][8*(3-off[1:0]) +: 8] <= data_byte;
            if (cmd.pad && !cmd.add_cv)
                blk_reg[pad_off[5:2]][8*(3-pad_off[1:0]) +: 8] <= PadByte;
            if (cmd.pad && cmd.add_cv)
                blk_reg[0] <= {PadByte, 24'd0};
            if (cmd.put_len) begin
                blk_reg[14] <= 32'((bits + (cmd.absorb ? 64'd8 : 64'd0)) >> 32);
                blk_reg[15] <= 32'(bits + (cmd.absorb ? 64'd8 : 64'd0));
            end
        end
    end

    a_round_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.round && rnd_reg != 6'd63) |=> run_reg) else $error("round stalled");
    a_init_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.init |=> cnt_reg == '0) else $error("count not cleared");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.round && cmd.absorb)) else $error("byte during rounds");
endmodule

>>> sv/sha256_stream_hash.sv
// Top level of the streaming SHA-256 / double SHA-256 hasher.
// Depends on sha_pkg, sha_ctrl and sha_dp.
//
//  channel  | direction | content
//  s_axis   | in        | tdata = data_byte; tuser = byte_present; tlast = end_of_message
//  m_axis   | out       | tdata = digest_word; tuser = word_index; tlast = last_word
//  cfg      | in        | double_hash write
//
// Requests are taken back to back when idle; every 64th byte starts a block's
// rounds in the single round unit, then a fold. End of message adds one or two
// blocks (two or three with double hash), then the eight digest words go out.
// Reset is synchronous, active low; input stalls during compression and output.
module sha256_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);
    import sha_pkg::*;

    sha_cmd_t   cmd;
    sha_stat_t  stat;
    logic [2:0] idx;
    logic       dbl_reg;

    // Hold the mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) dbl_reg <= 1'b0;
        else if (cfg_wr_en) dbl_reg <= cfg_wr_data;
    end

    sha_ctrl u_ctrl (
        .aclk, .aresetn,
        .req_valid(s_axis_tvalid), .req_byte(s_axis_tuser), .req_end(s_axis_tlast),
        .double_hash(dbl_reg), .stat, .out_taken(m_axis_tvalid && m_axis_tready),
        .req_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_index(idx), .cmd
    );

    sha_dp u_dp (
        .aclk, .aresetn, .cmd, .data_byte(s_axis_tdata), .out_index(idx),
        .stat, .digest(m_axis_tdata)
    );

    assign m_axis_tuser = idx;
    assign m_axis_tlast = (idx == 3'd7);
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sha256_stream_hash: drives byte requests, predicts
// the SHA-256 / double SHA-256 digest words, and compares them. Depends on the RTL.
module tb_top;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] byte_present
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [2:0]  m_axis_tuser;   // [2:0] word_index
    logic        m_axis_tlast;
    logic        cfg_wr_en;
    logic        cfg_wr_data;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       eom;
    } byte_req_t;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       eom;
        logic       dbl;
    } dir_row_t;

    localparam logic [31:0] K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam int TimeoutCycles = 1000000;
    localparam int DirRows = 9;

    // Directed rows: "abc", empty request, empty message, extreme bytes, both modes
    dir_row_t dir_tab [DirRows] = '{
        '{8'h61, 1'b1, 1'b0, 1'b0},
        '{8'h62, 1'b1, 1'b0, 1'b0},
        '{8'h63, 1'b1, 1'b1, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b0},
        '{8'h00, 1'b1, 1'b1, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1},
        '{8'hA5, 1'b1, 1'b1, 1'b1}
    };

    sha256_stream_hash dut (.*);

    // Predictor state
    logic [31:0]  hv [8];
    logic [31:0]  blk [16];
    logic [60:0]  nbytes;
    logic         dbl_mode;
    digest_beat_t digest_q [$];

    int  errors = 0;
    int  cycles = 0;
    int  n_beats = 0;
    int  n_msgs = 0;
    int  rx_wait = 0;
    bit  hold_off = 0;

    initial begin
        aclk = 0;
    end
    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run one 64-round compression of blk into hv, then clear blk
    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hv[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hv[i] += v[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
    endtask

    task automatic place_byte(logic [5:0] off, logic [7:0] b);
        blk[off[5:2]][8*(3-off[1:0]) +: 8] = b;
    endtask

    task automatic restart_msg();
        for (int i = 0; i < 8; i++) hv[i] = IV[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        nbytes = '0;
    endtask

    // Pad with the marker and the bit length, compress the tail
    task automatic pad_and_close();
        logic [5:0]  off;
        logic [63:0] bits;
        off = nbytes[5:0];
        bits = {nbytes, 3'b000};
        place_byte(off, 8'h80);
        if (off >= 6'd56) sha_compress();
        blk[14] = bits[63:32];
        blk[15] = bits[31:0];
        sha_compress();
    endtask

    // Advance the predictor by one accepted request; queue digest beats
    task automatic predict_hash(byte_req_t r);
        logic [31:0] first [8];
        digest_beat_t b;
        if (r.present) begin
            place_byte(nbytes[5:0], r.data);
            nbytes = nbytes + 1'b1;
            if (nbytes[5:0] == 6'd0) sha_compress();
        end
        if (!r.eom) return;
        pad_and_close();
        if (dbl_mode) begin
            for (int i = 0; i < 8; i++) first[i] = hv[i];
            restart_msg();
            for (int i = 0; i < 8; i++) blk[i] = first[i];
            nbytes = 61'd32;
            pad_and_close();
        end
        for (int i = 0; i < 8; i++) begin
            b.word = hv[i];
            b.idx = i[2:0];
            b.last = (i == 7);
            digest_q.push_back(b);
        end
        n_msgs++;
        restart_msg();
    endtask

    // Send one request with a random gap before it; valid stays up until
    // the next request or an explicit drop
    task automatic send_req(byte_req_t r);
        int gap;
        gap = $urandom_range(0, 14) * ($urandom_range(0, 3) != 0);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.data;
        s_axis_tuser  <= r.present;
        s_axis_tlast  <= r.eom;
        do @(posedge aclk); while (!s_axis_tready);
        predict_hash(r);
        @(negedge aclk);
    endtask

    task automatic send_msg(int len, bit present_on_eom, bit with_empties);
        byte_req_t r;
        for (int i = 0; i < len; i++) begin
            if (with_empties && $urandom_range(0, 9) == 0) begin
                r.data = 8'($urandom); r.present = 0; r.eom = 0;
                send_req(r);
            end
            r.data = 8'($urandom); r.present = 1;
            r.eom = present_on_eom && (i == len - 1);
            send_req(r);
        end
        if (!present_on_eom || len == 0) begin
            r.data = 8'($urandom); r.present = 0; r.eom = 1;
            send_req(r);
        end
    endtask

    // Change the mode only once every digest beat has drained
    task automatic write_mode(bit v);
        s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        dbl_mode = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: a drawn wait before each word, plus one long hold-off
    always @(negedge aclk) begin
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        wait (n_msgs == 3);
        hold_off = 1;
        repeat (400) @(posedge aclk);
        hold_off = 0;
    end

    // Compare each delivered digest word with the oldest prediction
    always @(posedge aclk) begin
        digest_beat_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_beats++;
            rx_wait = $urandom_range(0, 14);
            if (digest_q.size() == 0) begin
                $error("digest word 0x%08h with no prediction waiting", m_axis_tdata);
                errors++;
            end else begin
                e = digest_q.pop_front();
                if (m_axis_tdata !== e.word) begin
                    $error("digest_word exp %08h got %08h", e.word, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== e.idx) begin
                    $error("word_index exp %0d got %0d", e.idx, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_word exp %0d got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > TimeoutCycles) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        byte_req_t r;
        int lens [12] = '{0, 1, 3, 55, 56, 63, 64, 65, 7, 4, 0, 2};
        aresetn = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0; s_axis_tlast = 0;
        cfg_wr_en = 0; cfg_wr_data = 0;
        dbl_mode = 0;
        restart_msg();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table; predicted "abc" words 0 and 7 are checked against the published digest
        for (int i = 0; i < DirRows; i++) begin
            if (dir_tab[i].dbl != dbl_mode) write_mode(dir_tab[i].dbl);
            r.data = dir_tab[i].data;
            r.present = dir_tab[i].present;
            r.eom = dir_tab[i].eom;
            send_req(r);
            if (i == 2) begin
                if (digest_q.size() != 8) begin
                    $error("digest count exp 8 got %0d", digest_q.size());
                    errors++;
                end else begin
                    if (digest_q[0].word !== 32'hba7816bf) begin
                        $error("digest_word exp %08h got %08h", 32'hba7816bf,
                               digest_q[0].word);
                        errors++;
                    end
                    if (digest_q[7].word !== 32'hf20015ad) begin
                        $error("digest_word exp %08h got %08h", 32'hf20015ad,
                               digest_q[7].word);
                        errors++;
                    end
                end
            end
        end
        write_mode(0);

        // Random messages in both modes; lengths include short ones and ones around the padding boundaries
        for (int m = 0; m < 12; m++) begin
            if (m == 4) write_mode(1);
            if (m == 8) write_mode(0);
            send_msg(lens[m] == 0 ? 0 : $urandom_range(lens[m] > 3 ? lens[m] - 2 : 1, lens[m]),
                     1'($urandom_range(0, 1)), 1);
        end
        for (int m = 0; m < 4; m++) begin
            if (m == 2) write_mode(1);
            send_msg($urandom_range(0, 9), 1'($urandom_range(0, 1)), 1);
        end
        s_axis_tvalid <= 1'b0;

        while (digest_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("covered %0d messages, %0d digest words, both hash modes", n_msgs, n_beats);
        $display("lengths spanned the padding boundaries, a long receiver stall included");
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
